[hw/rtl/matrix_layer_rotation_assert.svh]
// Assertion helpers for the matrix layer rotation block.
`ifndef MATRIX_LAYER_ROTATION_ASSERT_SVH
`define MATRIX_LAYER_ROTATION_ASSERT_SVH

// Clocked property with active-low reset masking.
`define MLR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication form: antecedent in one cycle implies consequent in the same cycle.
`define MLR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/mlr_pkg.sv]
`timescale 1ns / 1ps

package mlr_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int IDX_W     = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int DIM_W     = IDX_W + 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;

    // longest ring: 2*(rows-1) + 2*(cols-1)
    localparam int RING_W = $clog2(2 * (MAX_ROWS + MAX_COLS) - 3);

    localparam int ELEM_W   = 32;
    localparam int CNT_W    = 7;
    localparam int STEP_W   = 31;
    localparam int BITCNT_W = $clog2(STEP_W);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ROW_COUNT      = 2'd0;
    localparam reg_idx_t REG_COL_COUNT      = 2'd1;
    localparam reg_idx_t REG_ROTATION_STEPS = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [2:0] state_t;
    localparam state_t ST_IDLE  = 3'd0;
    localparam state_t ST_LAYER = 3'd1;
    localparam state_t ST_RING  = 3'd2;
    localparam state_t ST_MOD   = 3'd3;
    localparam state_t ST_SRC   = 3'd4;
    localparam state_t ST_READ  = 3'd5;
    localparam state_t ST_DONE  = 3'd6;

    localparam logic [CNT_W-1:0]  ROW_COUNT_RST = 7'd2;
    localparam logic [CNT_W-1:0]  COL_COUNT_RST = 7'd2;
    localparam logic [STEP_W-1:0] ROT_STEPS_RST = '0;

endpackage

[hw/rtl/matrix_layer_rotation.sv]
// Matrix layer rotation. The block holds a matrix of 32-bit signed words in an
// internal 64x64 memory. A write transaction (op = 0) stores one element at the
// edge it is accepted; ready stays high, so writes can follow back to back. A read
// transaction (op = 1) returns the element found at the given row and column after
// every concentric layer of the row_count x col_count matrix has been rotated
// rotation_steps steps counter-clockwise. A read on a ring passes through the layer,
// ring, remainder, source, read and done states before the result appears on m_valid;
// the bit-serial remainder unit reduces rotation_steps modulo the ring length, one
// quotient bit per cycle. A read off any complete ring (middle row or column, or
// outside the matrix in use) skips the ring, remainder and source states. The block takes no new
// transaction while a read is in progress; a finished result sits in the output
// register, so the next transaction can be accepted while it waits for m_ready.
// Row and column counts above 64 are treated as 64. Configure over the APB port
// only while idle; an element must be written before it is read.
`timescale 1ns / 1ps
`include "matrix_layer_rotation_assert.svh"

module matrix_layer_rotation (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mlr_pkg::PADDR_W-1:0]      paddr,
    input  logic [mlr_pkg::PDATA_W-1:0]      pwdata,
    output logic [mlr_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [mlr_pkg::ROW_W-1:0]        s_row_index,
    input  logic [mlr_pkg::COL_W-1:0]        s_col_index,
    input  logic signed [mlr_pkg::ELEM_W-1:0] s_element_in,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [mlr_pkg::ELEM_W-1:0] m_element_out
);

    import mlr_pkg::*;

    // configuration registers
    logic [CNT_W-1:0]  row_count_reg;
    logic [CNT_W-1:0]  col_count_reg;
    logic [STEP_W-1:0] rotation_steps_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // control
    state_t                state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic [BITCNT_W-1:0]   bit_cnt_reg, bit_cnt_next;

    // datapath
    logic [IDX_W-1:0]      r_reg, c_reg;
    logic [IDX_W-1:0]      k_reg, bottom_reg, right_reg;
    logic [IDX_W-1:0]      h_reg, w_reg;
    logic [RING_W-1:0]     len_reg, p_reg;
    logic [RING_W:0]       rem_reg;
    logic [STEP_W-1:0]     div_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [ELEM_W-1:0]     element_out_reg;

    logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];

    logic s_fire;
    logic out_free;

    // layer stage
    logic [DIM_W-1:0] rows_d, cols_d, r_ext, c_ext, k_ext, k2;
    logic [DIM_W-1:0] dist_b, dist_r, bottom_d, right_d;
    logic [IDX_W-1:0] k_rc, k_br, k_val;
    logic             in_range, on_ring;

    // ring stage
    logic [IDX_W-1:0]  h_val, w_val;
    logic [RING_W-1:0] hx, wx, kx_r, rx, cx, botx, rgtx, len_val, p_val;

    // remainder unit
    logic [RING_W:0]   rem_shift, rem_val;

    // source stage
    logic [RING_W:0]   sum_val;
    logic [RING_W-1:0] s_val, t1, t2, t3, kx, bx, gx, sr_val, sc_val;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg      <= ROW_COUNT_RST;
            col_count_reg      <= COL_COUNT_RST;
            rotation_steps_reg <= ROT_STEPS_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ROW_COUNT:      row_count_reg      <= pwdata[CNT_W-1:0];
                REG_COL_COUNT:      col_count_reg      <= pwdata[CNT_W-1:0];
                REG_ROTATION_STEPS: rotation_steps_reg <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ROW_COUNT:      prdata = PDATA_W'(row_count_reg);
            REG_COL_COUNT:      prdata = PDATA_W'(col_count_reg);
            REG_ROTATION_STEPS: prdata = PDATA_W'(rotation_steps_reg);
            default:            prdata = '0;
        endcase
    end

    // nothing is taken while reset is held
    assign s_ready       = aresetn && (state_reg == ST_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_element_out = element_out_reg;
    assign out_free      = !m_valid_reg || m_ready;

    // ---- layer: which ring, and is it complete ----
    always_comb begin
        rows_d = (32'(row_count_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : DIM_W'(row_count_reg);
        cols_d = (32'(col_count_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : DIM_W'(col_count_reg);
        r_ext  = DIM_W'(r_reg);
        c_ext  = DIM_W'(c_reg);
        in_range = (r_ext < rows_d) && (c_ext < cols_d);
        dist_b = rows_d - DIM_W'(1) - r_ext;
        dist_r = cols_d - DIM_W'(1) - c_ext;
        k_rc   = (r_reg < c_reg) ? r_reg : c_reg;
        k_br   = (dist_b[IDX_W-1:0] < dist_r[IDX_W-1:0]) ? dist_b[IDX_W-1:0]
                                                         : dist_r[IDX_W-1:0];
        k_val  = (k_rc < k_br) ? k_rc : k_br;
        k_ext  = DIM_W'(k_val);
        k2     = {k_val, 1'b1};
        on_ring  = in_range && (k2 < rows_d) && (k2 < cols_d);
        bottom_d = rows_d - DIM_W'(1) - k_ext;
        right_d  = cols_d - DIM_W'(1) - k_ext;
    end

    // ---- ring: side lengths, ring length, position on the ring ----
    always_comb begin
        h_val   = bottom_reg - k_reg;
        w_val   = right_reg - k_reg;
        hx      = RING_W'(h_val);
        wx      = RING_W'(w_val);
        kx_r    = RING_W'(k_reg);
        rx      = RING_W'(r_reg);
        cx      = RING_W'(c_reg);
        botx    = RING_W'(bottom_reg);
        rgtx    = RING_W'(right_reg);
        len_val = (hx + wx) << 1;
        if (c_reg == k_reg) begin
            p_val = rx - kx_r;
        end else if (r_reg == bottom_reg) begin
            p_val = hx + (cx - kx_r);
        end else if (c_reg == right_reg) begin
            p_val = hx + wx + (botx - rx);
        end else begin
            p_val = (hx << 1) + wx + (rgtx - cx);
        end
    end

    // ---- restoring remainder, one dividend bit per cycle ----
    always_comb begin
        rem_shift = {rem_reg[RING_W-1:0], div_reg[STEP_W-1]};
        rem_val   = (rem_shift >= {1'b0, len_reg}) ? rem_shift - {1'b0, len_reg} : rem_shift;
    end

    // ---- source position on the ring ----
    always_comb begin
        sum_val = {1'b0, p_reg} + {1'b0, len_reg} - rem_reg;
        s_val   = (sum_val >= {1'b0, len_reg}) ? RING_W'(sum_val - {1'b0, len_reg})
                                               : RING_W'(sum_val);
        t1 = RING_W'(h_reg);
        t2 = RING_W'(h_reg) + RING_W'(w_reg);
        t3 = t2 + RING_W'(h_reg);
        kx = RING_W'(k_reg);
        bx = RING_W'(bottom_reg);
        gx = RING_W'(right_reg);
        if (s_val <= t1) begin
            sr_val = kx + s_val;
            sc_val = kx;
        end else if (s_val <= t2) begin
            sr_val = bx;
            sc_val = kx + (s_val - t1);
        end else if (s_val <= t3) begin
            sr_val = bx - (s_val - t2);
            sc_val = gx;
        end else begin
            sr_val = kx;
            sc_val = gx - (s_val - t3);
        end
    end

    // ---- sequencer ----
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        bit_cnt_next = bit_cnt_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_op == OP_READ)) begin
                    state_next = ST_LAYER;
                end
            end
            ST_LAYER: begin
                state_next = on_ring ? ST_RING : ST_READ;
            end
            ST_RING: begin
                state_next   = ST_MOD;
                bit_cnt_next = BITCNT_W'(STEP_W - 1);
            end
            ST_MOD: begin
                if (bit_cnt_reg == '0) begin
                    state_next = ST_SRC;
                end else begin
                    bit_cnt_next = bit_cnt_reg - BITCNT_W'(1);
                end
            end
            ST_SRC:  state_next = ST_READ;
            ST_READ: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    r_reg <= IDX_W'(s_row_index);
                    c_reg <= IDX_W'(s_col_index);
                end
            end
            ST_LAYER: begin
                k_reg      <= k_val;
                bottom_reg <= bottom_d[IDX_W-1:0];
                right_reg  <= right_d[IDX_W-1:0];
                addr_reg   <= {r_reg[ROW_W-1:0], c_reg[COL_W-1:0]};
            end
            ST_RING: begin
                h_reg   <= h_val;
                w_reg   <= w_val;
                len_reg <= len_val;
                p_reg   <= p_val;
                rem_reg <= '0;
                div_reg <= rotation_steps_reg;
            end
            ST_MOD: begin
                rem_reg <= rem_val;
                div_reg <= div_reg << 1;
            end
            ST_SRC: begin
                addr_reg <= {sr_val[ROW_W-1:0], sc_val[COL_W-1:0]};
            end
            ST_DONE: begin
                if (out_free) begin
                    element_out_reg <= rdata_reg[ELEM_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // element store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (s_fire && (s_op == OP_WRITE)) begin
            mem[{s_row_index, s_col_index}] <= DATA_WIDTH'(s_element_in);
        end
        if (state_reg == ST_READ) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    `MLR_ASSERT_IMPL(a_rem_bound, aclk, aresetn, state_reg == ST_MOD, rem_reg < {1'b0, len_reg}, "remainder not below ring length")
    `MLR_ASSERT_IMPL(a_src_on_ring, aclk, aresetn, state_reg == ST_SRC, s_val < len_reg, "source position off the ring")
    `MLR_ASSERT(a_result_from_done, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE, "result raised outside done state")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import mlr_pkg::*;

    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned DRAIN_CYCLES     = 60;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT   = 4000;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_op          = OP_WRITE;
    logic [ROW_W-1:0]     s_row_index   = '0;
    logic [COL_W-1:0]     s_col_index   = '0;
    logic signed [31:0]   s_element_in  = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic signed [31:0]   m_element_out;

    // mirror of the block's memory and registers
    logic [31:0]          matrix_mirror [MEM_DEPTH];
    bit                   written_mask  [MEM_DEPTH];
    logic [CNT_W-1:0]     row_cfg = ROW_COUNT_RST;
    logic [CNT_W-1:0]     col_cfg = COL_COUNT_RST;
    logic [STEP_W-1:0]    rot_cfg = ROT_STEPS_RST;

    logic signed [31:0]   pending_elements [$];
    int unsigned          items_sent        = 0;
    int unsigned          error_count       = 0;
    int unsigned          quiet_cycles      = 0;
    bit                   no_idle           = 1'b0;
    bit                   long_hold_pending = 1'b0;

    matrix_layer_rotation dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_row_index   (s_row_index),
        .s_col_index   (s_col_index),
        .s_element_in  (s_element_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_element_out (m_element_out)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Address {row, col} of the element that lands on (r_in, c_in) after rotation.
    function automatic logic [11:0] rotated_source(input logic [5:0] r_in,
                                                    input logic [5:0] c_in);
        int unsigned rows, cols, r, c, k, top, left, bottom, right;
        int unsigned h, w, ring_len, pos, src, sr, sc, rot;
        r    = 32'(r_in);
        c    = 32'(c_in);
        rot  = 32'(rot_cfg);
        rows = (row_cfg > 7'd64) ? 64 : 32'(row_cfg);
        cols = (col_cfg > 7'd64) ? 64 : 32'(col_cfg);
        if (r >= rows || c >= cols)
            return {r_in, c_in};
        k = (r < c) ? r : c;
        if (rows - 1 - r < k) k = rows - 1 - r;
        if (cols - 1 - c < k) k = cols - 1 - c;
        // leftover middle row or column: not on a full ring
        if (2 * k + 1 >= rows || 2 * k + 1 >= cols)
            return {r_in, c_in};
        top      = k;
        left     = k;
        bottom   = rows - 1 - k;
        right    = cols - 1 - k;
        h        = bottom - top;
        w        = right - left;
        ring_len = 2 * h + 2 * w;
        if (c == left)
            pos = r - top;
        else if (r == bottom)
            pos = h + (c - left);
        else if (c == right)
            pos = h + w + (bottom - r);
        else
            pos = 2 * h + w + (right - c);
        src = (pos + ring_len - (rot % ring_len)) % ring_len;
        if (src <= h) begin
            sr = top + src;
            sc = left;
        end else if (src - h <= w) begin
            sr = bottom;
            sc = left + (src - h);
        end else if (src - h - w <= h) begin
            sr = bottom - (src - h - w);
            sc = right;
        end else begin
            sr = top;
            sc = right - (src - 2 * h - w);
        end
        return {6'(sr), 6'(sc)};
    endfunction

    function automatic logic [31:0] random_element();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Entered and left just after a rising edge; valid stays up on return.
    task automatic send_item(input logic op, input logic [5:0] r, input logic [5:0] c,
                             input logic [31:0] value);
        int unsigned gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_row_index  <= r;
        s_col_index  <= c;
        s_element_in <= value;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        items_sent++;
        if (op == OP_WRITE) begin
            matrix_mirror[{r, c}] = value;
            written_mask[{r, c}]  = 1'b1;
        end else begin
            pending_elements.push_back(matrix_mirror[rotated_source(r, c)]);
        end
    endtask

    // Reads only after the source element has been stored.
    task automatic read_element(input logic [5:0] r, input logic [5:0] c);
        logic [11:0] src;
        src = rotated_source(r, c);
        if (!written_mask[src])
            send_item(OP_WRITE, src[11:6], src[5:0], random_element());
        send_item(OP_READ, r, c, $urandom);
    endtask

    // Write one register, then read it back.
    task automatic write_config(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] expected;
        s_valid <= 1'b0;
        while (pending_elements.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW_COUNT:      row_cfg = value[CNT_W-1:0];
            REG_COL_COUNT:      col_cfg = value[CNT_W-1:0];
            REG_ROTATION_STEPS: rot_cfg = value[STEP_W-1:0];
            default: ;
        endcase
        case (idx)
            REG_ROW_COUNT:      expected = 32'(row_cfg);
            REG_COL_COUNT:      expected = 32'(col_cfg);
            REG_ROTATION_STEPS: expected = 32'(rot_cfg);
            default:            expected = '0;
        endcase
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (pready !== 1'b1 || prdata !== expected) begin
            $error("prdata mismatch: expected %0d, actual %0d", expected, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned rows, input int unsigned cols,
                                input logic [30:0] rot);
        write_config(REG_ROW_COUNT, 32'(rows));
        write_config(REG_COL_COUNT, 32'(cols));
        write_config(REG_ROTATION_STEPS, {1'b0, rot});
    endtask

    task automatic run_phase(input int unsigned rows, input int unsigned cols,
                             input logic [30:0] rot, input int unsigned n_items);
        int unsigned stop_at, span_r, span_c;
        logic [5:0]  r, c;
        set_geometry(rows, cols, rot);
        span_r  = (rows > 64) ? 64 : rows;
        span_c  = (cols > 64) ? 64 : cols;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            // mostly inside the matrix in use, some anywhere in the store
            if (span_r == 0 || $urandom_range(0, 6) == 0)
                r = 6'($urandom_range(0, 63));
            else
                r = 6'($urandom_range(0, span_r - 1));
            if (span_c == 0 || $urandom_range(0, 6) == 0)
                c = 6'($urandom_range(0, 63));
            else
                c = 6'($urandom_range(0, span_c - 1));
            if ($urandom_range(0, 9) < 3)
                send_item(OP_WRITE, r, c, random_element());
            else
                read_element(r, c);
        end
    endtask

    task automatic test_reset_defaults();
        send_item(OP_WRITE, 6'd0, 6'd0, 32'h8000_0000);
        send_item(OP_WRITE, 6'd0, 6'd1, 32'h7FFF_FFFF);
        send_item(OP_WRITE, 6'd1, 6'd0, 32'h0000_0000);
        send_item(OP_WRITE, 6'd1, 6'd1, 32'hFFFF_FFFF);
        read_element(6'd0, 6'd0);
        read_element(6'd0, 6'd1);
        read_element(6'd1, 6'd0);
        read_element(6'd1, 6'd1);
    endtask

    task automatic test_field_extremes();
        // outside the matrix in use: stored and returned as is
        send_item(OP_WRITE, 6'd63, 6'd63, 32'hA5A5_5A5A);
        send_item(OP_WRITE, 6'd0, 6'd63, 32'h5A5A_A5A5);
        read_element(6'd63, 6'd63);
        read_element(6'd0, 6'd63);
    endtask

    task automatic test_leftover_middle();
        set_geometry(3, 5, 31'h7FFF_FFFF);
        read_element(6'd1, 6'd2);
        read_element(6'd0, 6'd0);
        read_element(6'd2, 6'd4);
    endtask

    task automatic test_count_limits();
        set_geometry(0, 2, 31'd5);
        read_element(6'd0, 6'd1);
        set_geometry(127, 1, 31'd1);
        read_element(6'd40, 6'd0);
        set_geometry(127, 127, 31'd1);
        read_element(6'd63, 6'd63);
        read_element(6'd0, 6'd0);
    endtask

    task automatic test_random_layers();
        run_phase(2, 2, 31'd0, 120);
        run_phase(4, 4, 31'd1, 140);
        run_phase(3, 7, 31'($urandom_range(0, 50)), 140);
        run_phase(7, 3, 31'($urandom), 140);
        run_phase(5, 5, 31'h7FFF_FFFF, 140);
        run_phase(8, 12, 31'($urandom), 140);
        run_phase(1, 9, 31'($urandom), 60);
        run_phase(2, 64, 31'($urandom), 100);
        run_phase(64, 2, 31'($urandom), 100);
        run_phase(64, 64, 31'($urandom), 120);
        run_phase(127, 100, 31'($urandom), 80);
        repeat (2)
            run_phase($urandom_range(2, 12), $urandom_range(2, 12), 31'($urandom), 120);
    endtask

    // Receiver stops for a long stretch while reads keep coming, so the
    // output register fills and the input side backs up.
    task automatic test_output_stall();
        set_geometry(6, 9, 31'($urandom));
        long_hold_pending = 1'b1;
        repeat (40)
            read_element(6'($urandom_range(0, 5)), 6'($urandom_range(0, 8)));
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        set_geometry(9, 6, 31'($urandom_range(0, 200)));
        repeat (30)
            send_item(OP_WRITE, 6'($urandom_range(0, 8)), 6'($urandom_range(0, 5)),
                      random_element());
        run_phase(9, 6, rot_cfg, 120);
        run_phase($urandom_range(2, 16), $urandom_range(2, 16), 31'($urandom), 120);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_field_extremes();
        test_leftover_middle();
        test_count_limits();
        test_random_layers();
        test_output_stall();
        test_back_to_back();
        s_valid <= 1'b0;
        while (pending_elements.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("** matrix_layer_rotation: PASSED **");
        else
            $display("** matrix_layer_rotation: FAILED **");
        $finish;
    end

    initial begin : result_sink
        int unsigned pick;
        forever begin
            @(posedge aclk);
            pick = $urandom_range(0, 15);
            if (long_hold_pending) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_pending = 1'b0;
                m_ready <= 1'b1;
            end else if (no_idle || pick > 2) begin
                m_ready <= 1'b1;
            end else if (pick == 2) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 150)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        logic signed [31:0] expected_value;
        if (aresetn && m_valid && m_ready) begin
            if (pending_elements.size() == 0) begin
                $error("element_out with no read pending: actual %0d", m_element_out);
                error_count++;
            end else begin
                expected_value = pending_elements.pop_front();
                if (m_element_out !== expected_value) begin
                    $error("element_out mismatch: expected %0d, actual %0d",
                           expected_value, m_element_out);
                    error_count++;
                end
            end
        end
    end

    // counts cycles without any transaction on either channel or the config port
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("** matrix_layer_rotation: FAILED **");
            $finish;
        end
    end

endmodule
